### hw/rtl/key_slot_vault_crc32_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the key vault
// Concurrent checks that disappear when the design is synthesized.
// ---------------------------------------------------------------------------
`ifndef KEY_SLOT_VAULT_CRC32_ASSERT_SVH
`define KEY_SLOT_VAULT_CRC32_ASSERT_SVH
`ifndef SYNTHESIS
`define KVC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key vault check failed");
`define KVC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key vault check failed");
`else
`define KVC_ASSERT_IMP(lbl, ante, cons)
`define KVC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/kvc_pkg.sv
// ---------------------------------------------------------------------------
// Key vault package
// Types, codes and the CRC-32 byte step shared by the vault modules.
// ---------------------------------------------------------------------------
package kvc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    localparam logic [2:0] REQ_FORMAT = 3'd0;
    localparam logic [2:0] REQ_WRITE  = 3'd1;
    localparam logic [2:0] REQ_READ   = 3'd2;
    localparam logic [2:0] REQ_DELETE = 3'd3;
    localparam logic [2:0] REQ_INFO   = 3'd4;

    localparam logic [2:0] RES_OK         = 3'd0;
    localparam logic [2:0] RES_BAD_SLOT   = 3'd1;
    localparam logic [2:0] RES_BAD_LENGTH = 3'd2;
    localparam logic [2:0] RES_IN_USE     = 3'd3;
    localparam logic [2:0] RES_NO_KEY     = 3'd4;
    localparam logic [2:0] RES_CRC        = 3'd5;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE  = 2'd1;
    localparam logic [1:0] SLOT_REVOKED = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WPAD  = 6'b000010,
        S_RSCAN = 6'b000100,
        S_RCHK  = 6'b001000,
        S_RREQ  = 6'b010000,
        S_RWAIT = 6'b100000
    } t_state;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] slot_id;
        logic [7:0] key_kind;
        logic [7:0] key_use;
        logic [7:0] key_length;
        logic [7:0] key_byte;
        logic       write_last;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_status;
        logic [7:0]  out_byte;
        logic [5:0]  out_index;
        logic        out_last;
        logic [7:0]  out_type;
        logic [7:0]  out_usage;
        logic [6:0]  out_length;
        logic [31:0] out_crc;
    } t_rsp;

    // One byte of the reflected CRC-32, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

### hw/rtl/kvc_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one vault request per transfer.
// ---------------------------------------------------------------------------
interface kvc_req_if import kvc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/kvc_rsp_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one vault result per transfer.
// ---------------------------------------------------------------------------
interface kvc_rsp_if import kvc_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/kvc_crc_unit.sv
// ---------------------------------------------------------------------------
// CRC step unit
// Advances a CRC-32 register by one data byte; shared by write and read.
// ---------------------------------------------------------------------------
module kvc_crc_unit import kvc_pkg::*; (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);
    assign o_crc = crc_byte(i_crc, i_byte);
endmodule

### hw/rtl/kvc_key_ram.sv
// ---------------------------------------------------------------------------
// Key data memory
// One write port and one registered read port, one byte per entry.
// ---------------------------------------------------------------------------
module kvc_key_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### hw/rtl/key_slot_vault_crc32.sv
// ---------------------------------------------------------------------------
// Write-once key vault with CRC-32
// Slots of key bytes guarded by a reflected CRC-32, with a small sequencer.
// ---------------------------------------------------------------------------
// Format, delete, info and write byte requests complete in the idle state. The last
// byte of a write pads the slot with zeros and folds them into the CRC, one
// byte per cycle. A read first walks all KEY_BYTES bytes through the CRC
// step, then emits the key bytes one at a time through the memory's read
// port, requesting each byte and then waiting for it and for a free result
// register. Key data is only ever read from active slots, and those were fully
// written, so the memory needs no clearing after reset or format; delete
// just revokes the header. A request is taken only while the sequencer is
// idle and the result register is empty.
module key_slot_vault_crc32 import kvc_pkg::*; #(
    parameter int SLOT_COUNT = 16,
    parameter int KEY_BYTES  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvc_req_if.sink    i_req,
    kvc_rsp_if.source  o_rsp
);
`include "key_slot_vault_crc32_assert.svh"

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW = $clog2(SLOT_COUNT * KEY_BYTES);
    localparam int IW = $clog2(KEY_BYTES + 1);

    logic [1:0]  r_hstate [SLOT_COUNT];
    logic [7:0]  r_hkind  [SLOT_COUNT];
    logic [7:0]  r_huse   [SLOT_COUNT];
    logic [6:0]  r_hlen   [SLOT_COUNT];
    logic [31:0] r_hcrc   [SLOT_COUNT];

    t_state      r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_slot, n_slot;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_use, n_use;
    logic [6:0]  r_len, n_len;
    logic [31:0] r_chk, n_chk;
    logic [IW-1:0] r_wcount, n_wcount;
    logic [31:0] r_wcrc, n_wcrc;
    logic [2:0]  r_wfault, n_wfault;
    logic [31:0] r_scrc, n_scrc;
    t_rsp        r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_req        req;
    logic        acc, out_free, slot_ok;
    logic [SW-1:0] s_idx;
    logic [2:0]  fault, nfault;
    logic        do_format, do_revoke, do_set;
    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic [31:0] crc_in, crc_out;
    logic [7:0]  crc_byte_in;

    function automatic logic [AW-1:0] mem_addr(input logic [SW-1:0] sl,
                                               input logic [IW-1:0] ix);
        return AW'(AW'(sl) * AW'(KEY_BYTES) + AW'(ix));
    endfunction

    assign req         = i_req.data;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign acc         = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign s_idx       = req.slot_id[SW-1:0];
    assign slot_ok     = {1'b0, req.slot_id} < 9'(SLOT_COUNT);
    assign ram_raddr   = mem_addr(r_slot, r_idx);

    kvc_crc_unit u_crc (
        .i_crc  (crc_in),
        .i_byte (crc_byte_in),
        .o_crc  (crc_out)
    );

    kvc_key_ram #(.DEPTH(SLOT_COUNT * KEY_BYTES), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Fault check of one write byte, in priority order.
    always_comb begin
        fault = RES_OK;
        if (!slot_ok) begin
            fault = RES_BAD_SLOT;
        end else if (req.key_length == 8'd0 || {1'b0, req.key_length} > 9'(KEY_BYTES)) begin
            fault = RES_BAD_LENGTH;
        end else if (r_hstate[s_idx] != SLOT_EMPTY) begin
            fault = RES_IN_USE;
        end else if (9'(r_wcount) >= {1'b0, req.key_length}) begin
            fault = RES_BAD_LENGTH;
        end else if (req.write_last && (9'(r_wcount) + 9'd1 != {1'b0, req.key_length})) begin
            fault = RES_BAD_LENGTH;
        end
        nfault = (r_wfault == RES_OK && fault != RES_OK) ? fault : r_wfault;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_kind      = r_kind;
        n_use       = r_use;
        n_len       = r_len;
        n_chk       = r_chk;
        n_wcount    = r_wcount;
        n_wcrc      = r_wcrc;
        n_wfault    = r_wfault;
        n_scrc      = r_scrc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        do_format   = 1'b0;
        do_revoke   = 1'b0;
        do_set      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = mem_addr(s_idx, r_wcount);
        ram_wdata   = req.key_byte;
        crc_in      = r_wcrc;
        crc_byte_in = req.key_byte;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (req.req_type)
                        REQ_FORMAT: begin
                            do_format   = 1'b1;
                            n_wcount    = '0;
                            n_wcrc      = CRC_ONES;
                            n_wfault    = RES_OK;
                            n_out       = '0;
                            n_out.out_last = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        REQ_WRITE: begin
                            if (nfault == RES_OK) begin
                                ram_we = 1'b1;
                                n_wcrc = crc_out;
                            end
                            n_wfault = nfault;
                            if (r_wcount < IW'(KEY_BYTES)) begin
                                n_wcount = r_wcount + 1'b1;
                            end
                            if (req.write_last) begin
                                n_wcount = '0;
                                n_wfault = RES_OK;
                                if (nfault != RES_OK) begin
                                    n_wcrc      = CRC_ONES;
                                    n_out       = '0;
                                    n_out.result_status = nfault;
                                    n_out.out_last = 1'b1;
                                    n_out_valid = 1'b1;
                                end else begin
                                    // Pad the rest of the slot with zeros.
                                    n_slot  = s_idx;
                                    n_kind  = req.key_kind;
                                    n_use   = req.key_use;
                                    n_len   = req.key_length[6:0];
                                    n_idx   = r_wcount + 1'b1;
                                    n_state = S_WPAD;
                                end
                            end
                        end
                        REQ_READ, REQ_DELETE, REQ_INFO: begin
                            n_out       = '0;
                            n_out.out_last = 1'b1;
                            if (!slot_ok) begin
                                n_out.result_status = RES_BAD_SLOT;
                                n_out_valid = 1'b1;
                            end else if (r_hstate[s_idx] != SLOT_ACTIVE) begin
                                n_out.result_status = RES_NO_KEY;
                                n_out_valid = 1'b1;
                            end else if (req.req_type == REQ_DELETE) begin
                                do_revoke   = 1'b1;
                                n_out_valid = 1'b1;
                            end else if (req.req_type == REQ_INFO) begin
                                n_out.out_type   = r_hkind[s_idx];
                                n_out.out_usage  = r_huse[s_idx];
                                n_out.out_length = r_hlen[s_idx];
                                n_out.out_crc    = r_hcrc[s_idx];
                                n_out_valid = 1'b1;
                            end else begin
                                n_slot  = s_idx;
                                n_kind  = r_hkind[s_idx];
                                n_use   = r_huse[s_idx];
                                n_len   = r_hlen[s_idx];
                                n_chk   = r_hcrc[s_idx];
                                n_scrc  = CRC_ONES;
                                n_idx   = '0;
                                n_state = S_RSCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WPAD: begin
                if (r_idx == IW'(KEY_BYTES)) begin
                    do_set      = 1'b1;
                    n_wcrc      = CRC_ONES;
                    n_out       = '0;
                    n_out.out_last   = 1'b1;
                    n_out.out_type   = r_kind;
                    n_out.out_usage  = r_use;
                    n_out.out_length = r_len;
                    n_out.out_crc    = ~r_wcrc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    ram_we      = 1'b1;
                    ram_waddr   = mem_addr(r_slot, r_idx);
                    ram_wdata   = 8'd0;
                    crc_byte_in = 8'd0;
                    n_wcrc      = crc_out;
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_RSCAN: begin
                // Read data arrives in the cycle after its address.
                crc_in      = r_scrc;
                crc_byte_in = ram_rdata;
                if (r_idx != '0) begin
                    n_scrc = crc_out;
                end
                if (r_idx == IW'(KEY_BYTES)) begin
                    n_state = S_RCHK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RCHK: begin
                if (out_free) begin
                    n_idx = '0;
                    if (~r_scrc != r_chk) begin
                        n_out       = '0;
                        n_out.result_status = RES_CRC;
                        n_out.out_last = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_RREQ;
                    end
                end
            end
            S_RREQ: begin
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                if (out_free) begin
                    n_out.result_status = RES_OK;
                    n_out.out_byte   = ram_rdata;
                    n_out.out_index  = 6'(r_idx);
                    n_out.out_last   = (8'(r_idx) + 8'd1 == {1'b0, r_len});
                    n_out.out_type   = r_kind;
                    n_out.out_usage  = r_use;
                    n_out.out_length = r_len;
                    n_out.out_crc    = r_chk;
                    n_out_valid = 1'b1;
                    if (8'(r_idx) + 8'd1 == {1'b0, r_len}) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RREQ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wcount    <= '0;
            r_wcrc      <= CRC_ONES;
            r_wfault    <= RES_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wcount    <= n_wcount;
            r_wcrc      <= n_wcrc;
            r_wfault    <= n_wfault;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_kind <= n_kind;
        r_use  <= n_use;
        r_len  <= n_len;
        r_chk  <= n_chk;
        r_scrc <= n_scrc;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_format) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_hstate[i] <= SLOT_EMPTY;
                r_hkind[i]  <= '0;
                r_huse[i]   <= '0;
                r_hlen[i]   <= '0;
                r_hcrc[i]   <= '0;
            end
        end else if (do_set) begin
            r_hstate[r_slot] <= SLOT_ACTIVE;
            r_hkind[r_slot]  <= r_kind;
            r_huse[r_slot]   <= r_use;
            r_hlen[r_slot]   <= r_len;
            r_hcrc[r_slot]   <= ~r_wcrc;
        end else if (do_revoke) begin
            r_hstate[s_idx] <= SLOT_REVOKED;
            r_hkind[s_idx]  <= '0;
            r_huse[s_idx]   <= '0;
            r_hlen[s_idx]   <= '0;
            r_hcrc[s_idx]   <= '0;
        end
    end

    `KVC_ASSERT_IMP(a_ready_idle, i_req.ready, r_state == S_IDLE && !r_out_valid)
    `KVC_ASSERT_IMP(a_count_range, 1'b1, r_wcount <= IW'(KEY_BYTES))
    `KVC_ASSERT_NXT(a_scan_done, r_state == S_RSCAN && r_idx == IW'(KEY_BYTES), r_state == S_RCHK)

endmodule

### tb/sv/kvc_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Key vault expected-result store
// Holds a shadow copy of the vault and the queue of results it should give.
// ---------------------------------------------------------------------------
package kvc_tb_pkg;
    import kvc_pkg::*;

    localparam int NSLOT = 16;
    localparam int NKEY  = 64;

    class vault_tracker;
        logic [1:0]  st [NSLOT];
        logic [7:0]  kind [NSLOT];
        logic [7:0]  usage [NSLOT];
        logic [6:0]  klen [NSLOT];
        logic [31:0] chk [NSLOT];
        logic [7:0]  mem [NSLOT*NKEY];
        int unsigned wcount;
        logic [31:0] wcrc;
        logic [2:0]  wfault;
        t_rsp        pending [$];
        int          errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < NSLOT; i++) begin
                st[i] = SLOT_EMPTY; kind[i] = 0; usage[i] = 0; klen[i] = 0; chk[i] = 0;
            end
            for (int i = 0; i < NSLOT*NKEY; i++) mem[i] = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            wcount = 0; wcrc = 32'hFFFFFFFF; wfault = RES_OK;
        endfunction

        function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            c = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
            return c;
        endfunction

        function void push(logic [2:0] s, logic [7:0] b, logic [5:0] ix, logic lst,
                           logic [7:0] t, logic [7:0] u, logic [6:0] l, logic [31:0] c);
            t_rsp r;
            r.result_status = s; r.out_byte = b; r.out_index = ix; r.out_last = lst;
            r.out_type = t; r.out_usage = u; r.out_length = l; r.out_crc = c;
            pending.push_back(r);
        endfunction

        function void push_hdr(int s);
            push(RES_OK, 0, 0, 1, kind[s], usage[s], klen[s], chk[s]);
        endfunction

        function void note_request(t_req q);
            logic [2:0] f;
            logic [31:0] c;
            int s, ix;
            s = q.slot_id;
            case (q.req_type)
                REQ_FORMAT: begin
                    wipe(); push(RES_OK, 0, 0, 1, 0, 0, 0, 0);
                end
                REQ_WRITE: begin
                    ix = wcount;
                    f = RES_OK;
                    if (s >= NSLOT) f = RES_BAD_SLOT;
                    else if (q.key_length == 0 || q.key_length > NKEY) f = RES_BAD_LENGTH;
                    else if (st[s] != SLOT_EMPTY) f = RES_IN_USE;
                    else if (ix >= q.key_length) f = RES_BAD_LENGTH;
                    else if (q.write_last && ix + 1 != q.key_length) f = RES_BAD_LENGTH;
                    if (wfault == RES_OK) wfault = f;
                    if (wfault == RES_OK) begin
                        mem[s*NKEY + ix] = q.key_byte;
                        wcrc = crc_step(wcrc, q.key_byte);
                    end
                    if (wcount < NKEY) wcount++;
                    if (q.write_last) begin
                        if (wfault == RES_OK) begin
                            c = wcrc;
                            for (int i = ix + 1; i < NKEY; i++) begin
                                mem[s*NKEY + i] = 0; c = crc_step(c, 8'd0);
                            end
                            chk[s] = ~c; st[s] = SLOT_ACTIVE; kind[s] = q.key_kind;
                            usage[s] = q.key_use; klen[s] = q.key_length;
                            push_hdr(s);
                        end else begin
                            push(wfault, 0, 0, 1, 0, 0, 0, 0);
                        end
                        clear_stream();
                    end
                end
                REQ_READ, REQ_DELETE, REQ_INFO: begin
                    if (s >= NSLOT) push(RES_BAD_SLOT, 0, 0, 1, 0, 0, 0, 0);
                    else if (st[s] != SLOT_ACTIVE) push(RES_NO_KEY, 0, 0, 1, 0, 0, 0, 0);
                    else if (q.req_type == REQ_READ) begin
                        c = 32'hFFFFFFFF;
                        for (int i = 0; i < NKEY; i++) c = crc_step(c, mem[s*NKEY + i]);
                        if (~c != chk[s]) push(RES_CRC, 0, 0, 1, 0, 0, 0, 0);
                        else if (klen[s] == 0) push_hdr(s);
                        else for (int i = 0; i < klen[s]; i++)
                            push(RES_OK, mem[s*NKEY + i], i, i + 1 == klen[s],
                                 kind[s], usage[s], klen[s], chk[s]);
                    end else if (q.req_type == REQ_DELETE) begin
                        for (int i = 0; i < NKEY; i++) mem[s*NKEY + i] = 0;
                        st[s] = SLOT_REVOKED; kind[s] = 0; usage[s] = 0; klen[s] = 0;
                        chk[s] = 0;
                        push(RES_OK, 0, 0, 1, 0, 0, 0, 0);
                    end else push_hdr(s);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_rsp a);
            t_rsp e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer"); errors++; return;
            end
            e = pending.pop_front();
            if (a.result_status !== e.result_status) begin
                $error("result_status exp %0d got %0d", e.result_status, a.result_status);
                errors++;
            end
            if (a.out_byte !== e.out_byte) begin
                $error("out_byte exp %0h got %0h", e.out_byte, a.out_byte); errors++;
            end
            if (a.out_index !== e.out_index) begin
                $error("out_index exp %0d got %0d", e.out_index, a.out_index); errors++;
            end
            if (a.out_last !== e.out_last) begin
                $error("out_last exp %0d got %0d", e.out_last, a.out_last); errors++;
            end
            if (a.out_type !== e.out_type) begin
                $error("out_type exp %0h got %0h", e.out_type, a.out_type); errors++;
            end
            if (a.out_usage !== e.out_usage) begin
                $error("out_usage exp %0h got %0h", e.out_usage, a.out_usage); errors++;
            end
            if (a.out_length !== e.out_length) begin
                $error("out_length exp %0d got %0d", e.out_length, a.out_length); errors++;
            end
            if (a.out_crc !== e.out_crc) begin
                $error("out_crc exp %0h got %0h", e.out_crc, a.out_crc); errors++;
            end
        endfunction
    endclass

endpackage

### tb/sv/tb_key_slot_vault_crc32.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Key vault testbench
// Directed and random requests with random gaps on both channels; every
// result transfer is compared with a shadow model of the vault.
// ---------------------------------------------------------------------------
module tb_key_slot_vault_crc32;
    import kvc_pkg::*;
    import kvc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    logic sink_on = 1'b0;
    int   sent = 0;

    kvc_req_if req_ch ();
    kvc_rsp_if rsp_ch ();
    vault_tracker vault = new();

    key_slot_vault_crc32 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check on each transfer, then stall at random.
    int stall = 0;
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) vault.check_result(rsp_ch.data);
        if (!sink_on) begin
            rsp_ch.ready <= 1'b0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if ((rsp_ch.valid && rsp_ch.ready) || !rsp_ch.ready) stall <= gap_len();
        end
    end

    // Valid stays high into the next request when there is no gap, so that
    // it is never assigned twice at the same edge.
    task automatic send(logic [2:0] rt, logic [7:0] sl, logic [7:0] kk, logic [7:0] ku,
                        logic [7:0] kl, logic [7:0] kb, logic lst);
        t_req q;
        int g;
        q.req_type = rt; q.slot_id = sl; q.key_kind = kk; q.key_use = ku;
        q.key_length = kl; q.key_byte = kb; q.write_last = lst;
        g = gap_len();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= q;
        do @(posedge i_clk); while (!req_ch.ready);
        vault.note_request(q);
        sent++;
    endtask

    task automatic write_key(logic [7:0] sl, logic [7:0] kl, int nbytes, logic rand_fields);
        logic [7:0] kk, ku;
        kk = rand_fields ? 8'($urandom) : 8'hA5;
        ku = rand_fields ? 8'($urandom) : 8'h3C;
        for (int i = 0; i < nbytes; i++)
            send(REQ_WRITE, sl, kk, ku, kl, 8'($urandom), i == nbytes - 1);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (vault.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    int p, sl, kl, n;
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on <= 1'b1;
        @(posedge i_clk);

        // Directed: format, extreme fields and every error result except RES_CRC.
        send(REQ_FORMAT, 0, 0, 0, 0, 0, 1);
        send(REQ_READ, 0, 0, 0, 0, 0, 0);
        send(REQ_INFO, 8'd255, 0, 0, 0, 0, 0);
        send(REQ_DELETE, 8'd16, 0, 0, 0, 0, 0);
        send(3'd7, 0, 0, 0, 0, 0, 1);
        send(REQ_WRITE, 0, 8'hFF, 8'hFF, 8'd1, 8'hFF, 1);
        send(REQ_WRITE, 0, 8'h00, 8'h00, 8'd1, 8'h00, 1);
        send(REQ_WRITE, 8'd200, 0, 0, 8'd1, 0, 1);
        send(REQ_WRITE, 1, 0, 0, 8'd0, 0, 1);
        send(REQ_WRITE, 1, 0, 0, 8'd255, 0, 1);
        send(REQ_WRITE, 1, 0, 0, 8'd3, 8'h5A, 1);
        write_key(1, 8'd2, 3, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 0);
        send(REQ_INFO, 0, 0, 0, 0, 0, 0);
        send(REQ_DELETE, 0, 0, 0, 0, 0, 0);
        send(REQ_INFO, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 0);
        write_key(15, 8'd64, 64, 0);
        send(REQ_READ, 15, 0, 0, 0, 0, 0);
        drain();

        // Random: mostly complete writes with reads, plus broken streams and noise.
        while (sent < 280) begin
            p = $urandom_range(0, 99);
            sl = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 15);
            if (p < 35) begin
                kl = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 8);
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, kl + 2) : kl;
                write_key(8'(sl), 8'(kl), n, 1);
            end else if (p < 40) begin
                send(REQ_WRITE, 8'(sl), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
            end else if (p < 65) begin
                send(REQ_READ, 8'(sl), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
            end else if (p < 77) begin
                send(REQ_INFO, 8'(sl), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
            end else if (p < 89) begin
                send(REQ_DELETE, 8'(sl), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
            end else if (p < 92) begin
                send(REQ_FORMAT, 8'(sl), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
            end else begin
                send(3'($urandom_range(5, 7)), 8'(sl), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 1'($urandom));
            end
            if (sent > 150 && sent < 160) drain();
        end

        drain();
        if (vault.errors == 0 && vault.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
